### rtl/core/dptc_pkg.sv
// Package for the drum pad trigger controller: constants, message and command
// codes, the controller/datapath command and status structs and a phase helper.
// Depends on nothing.
package dptc_pkg;

  localparam int TICKS_IN_BEAT    = 48;
  localparam int PAD_COUNT        = 12;
  localparam int HALF_BEAT        = 24;
  localparam int FIRST_PAD_COLUMN = 10;

  localparam int TICK_W    = 16;
  localparam int X_W       = 4;
  localparam int Y_W       = 3;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 4;
  localparam int PAD_W     = 4;
  localparam int COL_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int MODES_W   = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  localparam int REM_W      = $clog2(TICKS_IN_BEAT);
  localparam int REM1_W     = REM_W + 1;
  localparam int PHASE_W    = $clog2(HALF_BEAT);
  localparam int HALF_STEPS = TICKS_IN_BEAT / HALF_BEAT;
  localparam int PAD_IDX_W  = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  // The tick count is divided by one beat through a rounded-up reciprocal, which is exact
  // for every tick count of TICK_W bits.
  localparam int RECIP_SHIFT = TICK_W + REM_W;
  localparam int RECIP_W     = TICK_W + 1;
  localparam int QUOT_W      = TICK_W - REM_W + 1;
  localparam int PROD_W      = TICK_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + TICKS_IN_BEAT - 1) / TICKS_IN_BEAT);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_KEY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HIDE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd3;

  localparam logic [KIND_W-1:0] KIND_PAD       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_START     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_STOP      = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR_TAP = 4'd3;
  localparam logic [KIND_W-1:0] KIND_TAP       = 4'd4;
  localparam logic [KIND_W-1:0] KIND_DOWNBEAT  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_HALFBEAT  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_HIDE      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_LEDSET    = 4'd8;

  localparam logic [1:0] MODE_TRIG    = 2'd0;
  localparam logic [1:0] MODE_DUB_TAP = 2'd1;
  localparam logic [1:0] MODE_HOLD    = 2'd2;

  localparam logic [1:0] EMIT_START = 2'd0;
  localparam logic [1:0] EMIT_KEY   = 2'd1;
  localparam logic [1:0] EMIT_SCAN  = 2'd2;
  localparam logic [1:0] EMIT_LED   = 2'd3;

  typedef struct packed {
    logic       latch;
    logic       key_exec;
    logic       hide_exec;
    logic       stop_exec;
    logic       div_step;
    logic       rem_load;
    logic       match_load;
    logic       scan_step;
    logic       emit;
    logic [1:0] emit_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             out_free;
    logic             key_start_v;
    logic             key_msg_v;
    logic             mask_empty;
    logic             mask_lsb;
    logic             led_v;
  } ctrl_status_t;

  // Reduces a value no larger than one beat to its phase within the half beat.
  function automatic logic [PHASE_W-1:0] mod_half(input logic [REM1_W-1:0] v);
    logic [REM1_W-1:0] r;
    r = v;
    for (int k = 0; k < HALF_STEPS; k++) begin
      if (r >= REM1_W'(HALF_BEAT)) begin
        r = r - REM1_W'(HALF_BEAT);
      end
    end
    return r[PHASE_W-1:0];
  endfunction

endpackage

### rtl/core/dptc_ctrl.sv
// Sequencing state machine of the drum pad trigger controller.
// Depends on dptc_pkg; drives the datapath by command and reads its status.
module dptc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  dptc_pkg::ctrl_status_t st,
  output dptc_pkg::ctrl_cmd_t    cmd
);
  import dptc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_MATCH  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_LED    = 3'd5;
  localparam logic [2:0] S_KSTART = 3'd6;
  localparam logic [2:0] S_KMSG   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.cmd)
          CMD_KEY: begin
            cmd.key_exec = 1'b1;
            state_nxt    = S_KSTART;
          end
          CMD_TICK: begin
            cmd.div_step = 1'b1;
            state_nxt    = S_DIV;
          end
          CMD_HIDE: begin
            cmd.hide_exec = 1'b1;
            state_nxt     = S_IDLE;
          end
          default: begin
            cmd.stop_exec = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        cmd.rem_load = 1'b1;
        state_nxt    = S_MATCH;
      end
      S_MATCH: begin
        cmd.match_load = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (st.mask_empty) begin
          state_nxt = S_LED;
        end else if (!st.mask_lsb) begin
          cmd.scan_step = 1'b1;
        end else if (st.out_free) begin
          cmd.scan_step = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_SCAN;
        end
      end
      S_LED: begin
        if (!st.led_v) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LED;
          state_nxt    = S_IDLE;
        end
      end
      S_KSTART: begin
        if (!st.key_start_v) begin
          state_nxt = S_KMSG;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_START;
          state_nxt    = S_KMSG;
        end
      end
      S_KMSG: begin
        if (!st.key_msg_v) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_KEY;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_div_leads_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_MATCH))
    else $error("tick remainder finished without loading the match mask");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_tready)
    else $error("new word taken while the previous one is still at work");
  a_one_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !cmd.latch && !cmd.div_step && !cmd.match_load)
    else $error("message issued alongside an unrelated command");

endmodule

### rtl/core/dptc_datapath.sv
// Datapath of the drum pad trigger controller: pad and transport state,
// tick remainder unit, held pad match scan and the output register.
// Depends on dptc_pkg; commanded by dptc_ctrl.
module dptc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dptc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [dptc_pkg::X_W-1:0]       in_key_x,
  input  logic [dptc_pkg::Y_W-1:0]       in_key_y,
  input  logic                           in_key_down,
  input  logic [dptc_pkg::TICK_W-1:0]    in_tick_value,
  input  logic                           cfg_we,
  input  logic [dptc_pkg::MODES_W-1:0]   cfg_wdata,
  input  dptc_pkg::ctrl_cmd_t             cmd,
  output dptc_pkg::ctrl_status_t          st,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dptc_pkg::KIND_W-1:0]    out_kind,
  output logic [dptc_pkg::PAD_W-1:0]     out_pad,
  output logic [dptc_pkg::COL_W-1:0]     out_col,
  output logic                           out_last
);
  import dptc_pkg::*;

  logic [MODES_W-1:0]   pad_modes_r;
  logic                 running_r, running_nxt;
  logic [COUNT_W-1:0]   tkc_r, tkc_nxt;
  logic [COUNT_W-1:0]   press_r [PAD_COUNT];
  logic [COUNT_W-1:0]   press_nxt [PAD_COUNT];
  logic [PAD_COUNT-1:0] hold_r, hold_nxt;
  logic [PHASE_W-1:0]   phase_r [PAD_COUNT];
  logic [REM_W-1:0]     prev_tick_r, prev_tick_nxt;

  logic [CMD_W-1:0]     cmd_r;
  logic [X_W-1:0]       kx_r;
  logic [Y_W-1:0]       ky_r;
  logic                 kdown_r;
  logic [TICK_W-1:0]    tv_r;
  logic [QUOT_W-1:0]    quot_r;
  logic [REM_W-1:0]     rem_r;

  logic [PAD_COUNT-1:0] mask_r;
  logic [PAD_W-1:0]     scan_idx_r;
  logic                 led_v_r;
  logic [KIND_W-1:0]    led_kind_r;

  logic                 ks_r, ks_nxt;
  logic                 km_r, km_nxt;
  logic [KIND_W-1:0]    kk_r, kk_nxt;
  logic [PAD_W-1:0]     kp_r, kp_nxt;
  logic [COL_W-1:0]     kc_r, kc_nxt;

  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r;
  logic [PAD_W-1:0]     out_pad_r;
  logic [COL_W-1:0]     out_col_r;
  logic                 out_last_r;

  logic [X_W-1:0]       xoff;
  logic [PAD_W-1:0]     p;
  logic [PAD_IDX_W-1:0] pidx;
  logic                 pad_ok;
  logic [1:0]           mode;
  logic [COUNT_W-1:0]   cnt_new;
  logic [COUNT_W-1:0]   tkc_inc;
  logic [PHASE_W-1:0]   phase_arm;
  logic                 phase_we;
  logic [PROD_W-1:0]    recip_prod;
  logic [TICK_W-1:0]    quot_beats;
  logic [TICK_W-1:0]    rem_full;
  logic [PHASE_W-1:0]   t_half;
  logic [PAD_COUNT-1:0] mask_load;
  logic                 out_free;

  function automatic logic [X_W-1:0] in_key_x_latched_off(input logic [X_W-1:0] x);
    return x - X_W'(FIRST_PAD_COLUMN);
  endfunction

  assign xoff       = in_key_x_latched_off(kx_r);
  assign p          = {xoff[2:1], ky_r[2:1]};
  assign pad_ok     = (p < PAD_W'(PAD_COUNT));
  assign pidx       = p[PAD_IDX_W-1:0];
  assign mode       = pad_modes_r[{p, 1'b0} +: 2];
  assign tkc_inc    = (tkc_r < COUNT_MAX) ? tkc_r + 1'b1 : tkc_r;
  assign phase_arm  = mod_half({1'b0, prev_tick_r} + REM1_W'(1));
  assign recip_prod = {{RECIP_W{1'b0}}, tv_r} * {{TICK_W{1'b0}}, RECIP};
  assign quot_beats = {{(TICK_W-QUOT_W){1'b0}}, quot_r} * TICK_W'(TICKS_IN_BEAT);
  assign rem_full   = tv_r - quot_beats;
  assign t_half     = mod_half({1'b0, rem_r});
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    for (int i = 0; i < PAD_COUNT; i++) begin
      mask_load[i] = hold_r[i] && (phase_r[i] == t_half);
    end
  end

  always_comb begin
    press_nxt     = press_r;
    tkc_nxt       = tkc_r;
    hold_nxt      = hold_r;
    running_nxt   = running_r;
    prev_tick_nxt = prev_tick_r;
    phase_we      = 1'b0;
    cnt_new       = press_r[pidx];
    ks_nxt        = ks_r;
    km_nxt        = km_r;
    kk_nxt        = kk_r;
    kp_nxt        = kp_r;
    kc_nxt        = kc_r;
    if (cmd.key_exec) begin
      ks_nxt = 1'b0;
      km_nxt = 1'b0;
      kk_nxt = KIND_PAD;
      kp_nxt = '0;
      kc_nxt = '0;
      if (!kx_r[X_W-1]) begin
        if (!kdown_r) begin
          if (ky_r >= Y_W'(1) && ky_r <= Y_W'(3) && tkc_r != '0) begin
            tkc_nxt = tkc_r - 1'b1;
          end
        end else if (ky_r == '0) begin
          km_nxt = 1'b1;
          if (running_r) begin
            kk_nxt = KIND_STOP;
          end else begin
            kk_nxt = KIND_LEDSET;
            kc_nxt = kx_r[COL_W-1:0];
          end
        end else if (ky_r <= Y_W'(3)) begin
          tkc_nxt = tkc_inc;
          if (tkc_inc == COUNT_W'(1)) begin
            if (kx_r < X_W'(3)) begin
              km_nxt = 1'b1;
              kk_nxt = KIND_CLEAR_TAP;
            end else if (kx_r < X_W'(6)) begin
              km_nxt = 1'b1;
              kk_nxt = KIND_TAP;
            end
          end
        end else if (ky_r == Y_W'(7) && kx_r == '0) begin
          km_nxt = 1'b1;
          kk_nxt = KIND_HIDE;
          tkc_nxt = '0;
          for (int i = 0; i < PAD_COUNT; i++) begin
            press_nxt[i] = '0;
          end
        end
      end else if (kx_r >= X_W'(FIRST_PAD_COLUMN) && pad_ok) begin
        if (kdown_r) begin
          if (press_r[pidx] < COUNT_MAX) begin
            cnt_new = press_r[pidx] + 1'b1;
          end
          ks_nxt = !running_r;
          if (cnt_new == COUNT_W'(1)) begin
            if (mode == MODE_TRIG || mode == MODE_DUB_TAP) begin
              km_nxt = 1'b1;
              kp_nxt = p;
            end else if (mode == MODE_HOLD) begin
              hold_nxt[pidx] = 1'b1;
              phase_we       = 1'b1;
            end
          end
        end else begin
          if (press_r[pidx] != '0) begin
            cnt_new = press_r[pidx] - 1'b1;
          end
          if (cnt_new == '0) begin
            if (mode == MODE_DUB_TAP) begin
              km_nxt = 1'b1;
              kp_nxt = p;
            end else if (mode == MODE_HOLD) begin
              hold_nxt[pidx] = 1'b0;
            end
          end
        end
        press_nxt[pidx] = cnt_new;
      end
    end
    if (cmd.hide_exec) begin
      hold_nxt = '0;
      tkc_nxt  = '0;
      for (int i = 0; i < PAD_COUNT; i++) begin
        press_nxt[i] = '0;
      end
    end
    if (cmd.stop_exec) begin
      running_nxt = 1'b0;
    end
    if (cmd.match_load) begin
      running_nxt   = 1'b1;
      prev_tick_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_modes_r <= '0;
      running_r   <= 1'b0;
      tkc_r       <= '0;
      press_r     <= '{default: '0};
      hold_r      <= '0;
      prev_tick_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pad_modes_r <= cfg_wdata;
      end
      running_r   <= running_nxt;
      tkc_r       <= tkc_nxt;
      press_r     <= press_nxt;
      hold_r      <= hold_nxt;
      prev_tick_r <= prev_tick_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_we) begin
      phase_r[pidx] <= phase_arm;
    end
    ks_r <= ks_nxt;
    km_r <= km_nxt;
    kk_r <= kk_nxt;
    kp_r <= kp_nxt;
    kc_r <= kc_nxt;
    if (cmd.latch) begin
      cmd_r   <= in_cmd;
      kx_r    <= in_key_x;
      ky_r    <= in_key_y;
      kdown_r <= in_key_down;
      tv_r    <= in_tick_value;
    end
    if (cmd.div_step) begin
      quot_r <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd.rem_load) begin
      rem_r <= rem_full[REM_W-1:0];
    end
    if (cmd.match_load) begin
      mask_r     <= mask_load;
      scan_idx_r <= '0;
      led_v_r    <= (rem_r == '0) || (rem_r == REM_W'(HALF_BEAT));
      led_kind_r <= (rem_r == '0) ? KIND_DOWNBEAT : KIND_HALFBEAT;
    end else if (cmd.scan_step) begin
      mask_r     <= mask_r >> 1;
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.emit) begin
      out_pad_r <= '0;
      out_col_r <= '0;
      case (cmd.emit_sel)
        EMIT_START: begin
          out_kind_r <= KIND_START;
          out_last_r <= !km_r;
        end
        EMIT_KEY: begin
          out_kind_r <= kk_r;
          out_pad_r  <= kp_r;
          out_col_r  <= kc_r;
          out_last_r <= 1'b1;
        end
        EMIT_SCAN: begin
          out_kind_r <= KIND_PAD;
          out_pad_r  <= scan_idx_r;
          out_last_r <= ((mask_r >> 1) == '0) && !led_v_r;
        end
        default: begin
          out_kind_r <= led_kind_r;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign st.cmd         = cmd_r;
  assign st.out_free    = out_free;
  assign st.key_start_v = ks_r;
  assign st.key_msg_v   = km_r;
  assign st.mask_empty  = (mask_r == '0);
  assign st.mask_lsb    = mask_r[0];
  assign st.led_v       = led_v_r;

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_pad    = out_pad_r;
  assign out_col    = out_col_r;
  assign out_last   = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("output register overwritten before its word was taken");
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (mask_r != '0))
    else $error("scan stepped past the last matching pad");
  a_tick_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match_load |=> running_r)
    else $error("tick did not set the transport running");
  a_key_only_for_key: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.key_exec |-> (cmd_r == CMD_KEY))
    else $error("key handling started for a word that is not a key event");

endmodule

### rtl/core/drum_pad_trigger_controller.sv
// Drum pad trigger controller top level; depends on dptc_pkg, dptc_ctrl and dptc_datapath.
// A word is taken only when the previous one is finished: a key event passes the execute,
// start and key message states, hide and stop only execute, and a tick the two-step
// reciprocal remainder, match load, one-pad-a-cycle hold scan (held while output is busy)
// to the highest matching held pad, and LED message. Results are registered into one output
// register. Synchronous active-low reset clears only control, pad, transport and valid state.
module drum_pad_trigger_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: key_x[3:0], key_y[6:4], key_down[7], tick_value[23:8].
  input  logic [dptc_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [dptc_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: pad[3:0], led_column[6:4], zero[7].
  output logic [dptc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Fields from bit 0: msg_kind[3:0].
  output logic [dptc_pkg::KIND_W-1:0]       out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [dptc_pkg::MODES_W-1:0]      cfg_wdata
);
  import dptc_pkg::*;

  ctrl_cmd_t        cmd;
  ctrl_status_t     st;
  logic [PAD_W-1:0] out_pad;
  logic [COL_W-1:0] out_col;

  dptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  dptc_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_tuser),
    .in_key_x      (in_tdata[3:0]),
    .in_key_y      (in_tdata[6:4]),
    .in_key_down   (in_tdata[7]),
    .in_tick_value (in_tdata[23:8]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .st            (st),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_kind      (out_tuser),
    .out_pad       (out_pad),
    .out_col       (out_col),
    .out_last      (out_tlast)
  );

  assign out_tdata = {1'b0, out_col, out_pad};

endmodule

### tb/sv/tb.sv
// Self-checking testbench for drum_pad_trigger_controller: a scoreboard class predicts the
// message words for every accepted input word, and plain tasks drive random and directed traffic.
// Depends on dptc_pkg and the drum_pad_trigger_controller RTL.
`timescale 1ns / 1ps

module tb;
  import dptc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAD_W-1:0]  pad;
    logic [COL_W-1:0]  col;
    logic              last;
  } msg_t;

  class pad_msg_scoreboard;
    msg_t due_msgs[$];
    int mismatches = 0;
    int results_seen = 0;
    bit [MODES_W-1:0] modes = '0;
    bit running = 1'b0;
    bit [COUNT_W-1:0] key_count = '0;
    bit [COUNT_W-1:0] press_count[PAD_COUNT];
    bit [PAD_COUNT-1:0] held = '0;
    bit [4:0] hold_ph[PAD_COUNT];
    bit [5:0] prev_tick = '0;

    function msg_t mk(logic [KIND_W-1:0] kind, int pad, logic [COL_W-1:0] col);
      msg_t m;
      m.kind = kind;
      m.pad = PAD_W'(pad);
      m.col = col;
      m.last = 1'b0;
      return m;
    endfunction

    function void clear_counts();
      foreach (press_count[i]) press_count[i] = '0;
      key_count = '0;
    endfunction

    function void predict_messages(logic [CMD_W-1:0] cmd, logic [X_W-1:0] kx,
                                   logic [Y_W-1:0] ky, logic dn, logic [TICK_W-1:0] tv);
      msg_t batch[$];
      int p;
      int t;
      logic [1:0] m;
      case (cmd)
        CMD_KEY: begin
          if (kx < 8) begin
            if (!dn) begin
              if (ky >= 1 && ky <= 3 && key_count != 0) key_count--;
            end else if (ky == 0) begin
              if (running) batch.push_back(mk(KIND_STOP, 0, '0));
              else batch.push_back(mk(KIND_LEDSET, 0, kx[COL_W-1:0]));
            end else if (ky <= 3) begin
              if (key_count != COUNT_MAX) key_count++;
              if (key_count == 1) begin
                if (kx < 3) batch.push_back(mk(KIND_CLEAR_TAP, 0, '0));
                else if (kx < 6) batch.push_back(mk(KIND_TAP, 0, '0));
              end
            end else if (ky == 7 && kx == 0) begin
              batch.push_back(mk(KIND_HIDE, 0, '0));
              clear_counts();
            end
          end else if (kx >= FIRST_PAD_COLUMN) begin
            p = ((int'(kx) - FIRST_PAD_COLUMN) / 2) * 4 + int'(ky) / 2;
            if (p < PAD_COUNT) begin
              m = modes[2*p +: 2];
              if (dn) begin
                if (press_count[p] != COUNT_MAX) press_count[p]++;
                if (!running) batch.push_back(mk(KIND_START, 0, '0));
                if (press_count[p] == 1) begin
                  if (m == MODE_TRIG || m == MODE_DUB_TAP) begin
                    batch.push_back(mk(KIND_PAD, p, '0));
                  end else if (m == MODE_HOLD) begin
                    held[p] = 1'b1;
                    hold_ph[p] = 5'((int'(prev_tick) + 1) % HALF_BEAT);
                  end
                end
              end else begin
                if (press_count[p] != 0) press_count[p]--;
                if (press_count[p] == 0) begin
                  if (m == MODE_DUB_TAP) batch.push_back(mk(KIND_PAD, p, '0));
                  else if (m == MODE_HOLD) held[p] = 1'b0;
                end
              end
            end
          end
        end
        CMD_TICK: begin
          t = int'(tv) % TICKS_IN_BEAT;
          running = 1'b1;
          for (int i = 0; i < PAD_COUNT; i++) begin
            if (held[i] && (t % HALF_BEAT) == int'(hold_ph[i])) batch.push_back(mk(KIND_PAD, i, '0));
          end
          if (t == 0) batch.push_back(mk(KIND_DOWNBEAT, 0, '0));
          else if (t == HALF_BEAT) batch.push_back(mk(KIND_HALFBEAT, 0, '0));
          prev_tick = 6'(t);
        end
        CMD_HIDE: begin
          held = '0;
          clear_counts();
        end
        default: running = 1'b0;
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) due_msgs.push_back(batch[i]);
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_message(logic [KIND_W-1:0] kind, logic [PAD_W-1:0] pad,
                       logic [COL_W-1:0] col, logic last);
      msg_t want;
      results_seen++;
      if (due_msgs.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d pad %0d col %0d last %0b",
                                  kind, pad, col, last));
      end else begin
        want = due_msgs.pop_front();
        if ({kind, pad, col, last} !== want) begin
          report_mismatch($sformatf("kind %0d/%0d pad %0d/%0d col %0d/%0d last %0b/%0b (got/exp)",
                                    kind, want.kind, pad, want.pad, col, want.col, last, want.last));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [MODES_W-1:0] cfg_wdata = '0;

  pad_msg_scoreboard sb;
  int words_in = 0;
  int settings = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [TICK_W-1:0] tick_ctr = '0;

  drum_pad_trigger_controller dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_message(out_tuser, out_tdata[3:0], out_tdata[6:4], out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("drum_pad_trigger_controller regression: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [X_W-1:0] x,
                           input logic [Y_W-1:0] y, input logic dn,
                           input logic [TICK_W-1:0] tv);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tv, dn, y, x};
    in_tuser <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_messages(c, x, y, dn, tv);
    words_in++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modes(input logic [MODES_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.modes = v;
    settings++;
  endtask

  task automatic run_random(input int n_items);
    int done;
    int r;
    int reps;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      x = X_W'($urandom);
      y = Y_W'($urandom);
      if (r < 35) begin
        tick_ctr = ($urandom_range(0, 9) == 0) ? TICK_W'($urandom) : tick_ctr + 1'b1;
        send_item(CMD_TICK, x, y, 1'($urandom), tick_ctr);
        done++;
      end else if (r < 65) begin
        send_item(CMD_KEY, X_W'($urandom_range(10, 15)), y, $urandom_range(0, 99) < 55,
                  TICK_W'($urandom));
        done++;
      end else if (r < 67) begin
        if ($urandom_range(0, 1) == 0) begin
          x = X_W'($urandom_range(10, 15));
        end else begin
          x = X_W'($urandom_range(0, 5));
          y = Y_W'($urandom_range(1, 3));
        end
        reps = $urandom_range(13, 17);
        repeat (reps) send_item(CMD_KEY, x, y, 1'b1, TICK_W'($urandom));
        repeat (reps + 1) send_item(CMD_KEY, x, y, 1'b0, TICK_W'($urandom));
        done += 2 * reps + 1;
      end else if (r < 88) begin
        x = X_W'($urandom_range(0, 9));
        if ($urandom_range(0, 3) == 0) y = Y_W'($urandom_range(4, 7));
        else y = Y_W'($urandom_range(0, 3));
        send_item(CMD_KEY, x, y, 1'($urandom), TICK_W'($urandom));
        done++;
      end else if (r < 94) begin
        send_item(CMD_HIDE, x, y, 1'($urandom), TICK_W'($urandom));
        done++;
      end else begin
        send_item(CMD_STOP, x, y, 1'($urandom), TICK_W'($urandom));
        done++;
      end
    end
  endtask

  initial begin
    logic [MODES_W-1:0] v;
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pad p runs in mode p mod 4: trig, dub tap, hold, inert.
    write_modes(24'hE4E4E4);
    send_item(CMD_KEY, 4'd0, 3'd0, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd7, 3'd0, 1'b1, 16'hFFFF);
    send_item(CMD_KEY, 4'd10, 3'd0, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd10, 3'd1, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd10, 3'd2, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd10, 3'd3, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd10, 3'd2, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd11, 3'd4, 1'b1, 16'h0000);
    send_item(CMD_TICK, 4'd0, 3'd0, 1'b0, 16'd0);
    send_item(CMD_TICK, 4'd15, 3'd7, 1'b1, 16'd1);
    send_item(CMD_TICK, 4'd0, 3'd0, 1'b0, 16'd24);
    send_item(CMD_TICK, 4'd0, 3'd0, 1'b0, 16'hFFFF);
    send_item(CMD_KEY, 4'd15, 3'd7, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd10, 3'd5, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd0, 3'd0, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd2, 3'd1, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd3, 3'd2, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd3, 3'd2, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd2, 3'd1, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd5, 3'd3, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd6, 3'd1, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd0, 3'd7, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd1, 3'd5, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd8, 3'd0, 1'b1, 16'h0000);
    send_item(CMD_KEY, 4'd9, 3'd7, 1'b1, 16'h0000);
    send_item(CMD_HIDE, 4'd0, 3'd0, 1'b0, 16'h0000);
    send_item(CMD_STOP, 4'd0, 3'd0, 1'b0, 16'h0000);
    send_item(CMD_KEY, 4'd12, 3'd0, 1'b1, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: v = 24'h000000;
        1: v = 24'hFFFFFF;
        2: v = 24'h555555;
        3: v = 24'hAAAAAA;
        default: v = MODES_W'($urandom);
      endcase
      write_modes(v);
      if (ph == 7) begin
        gap_pct = 0;
        stall_pct <= 0;
      end else begin
        gap_pct = $urandom_range(0, 2) * 15;
        stall_pct <= $urandom_range(0, 2) * 15;
      end
      run_random(24);
    end
    drain();

    if (sb.due_msgs.size() != 0) sb.report_mismatch("expected words left over at the end");
    $display("covered %0d input words and %0d result words under %0d pad mode settings",
             words_in, sb.results_seen, settings);
    if (sb.mismatches == 0) begin
      $display("drum_pad_trigger_controller regression: pass");
    end else begin
      $display("drum_pad_trigger_controller regression: fail");
    end
    $finish;
  end
endmodule
